>>> design/ghalloc_pkg.sv
// Shared constants, request and status codes, and the command/status structs
// passed between the allocator controller and datapath.
// No dependencies.
package ghalloc_pkg;

  localparam int MAX_SLOTS    = 1024;
  localparam int VERSION_BITS = 16;
  localparam int MAX_BATCH    = 16;
  localparam int RESULT_LIMIT = 16;

  localparam int BATCH_LIM = (MAX_BATCH < RESULT_LIMIT) ? MAX_BATCH : RESULT_LIMIT;

  localparam int IDX_W = $clog2(MAX_SLOTS);
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int REM_W = $clog2(BATCH_LIM + 1);
  localparam int VER_W = VERSION_BITS;

  // fixed port field widths
  localparam int REQ_W    = 3;
  localparam int COUNT_W  = 5;
  localparam int HIDX_W   = 10;
  localparam int HVER_W   = 16;
  localparam int STATUS_W = 2;

  localparam logic [REQ_W-1:0] REQ_CREATE      = 3'd0;
  localparam logic [REQ_W-1:0] REQ_CREATE_MANY = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DESTROY     = 3'd2;
  localparam logic [REQ_W-1:0] REQ_IS_ALIVE    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR       = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SRC_POP    = 2'd0,
    SRC_APPEND = 2'd1,
    SRC_STATUS = 2'd2
  } out_src_t;

  typedef struct packed {
    logic     load;       // capture request fields
    logic     pop_rd;     // read top of free stack, drop free count
    logic     slot_rd;    // read version of popped slot
    logic     req_rd;     // read version of requested handle
    logic     append;     // write version 1 to a fresh slot
    logic     commit;     // bump version and push slot
    logic     clear_all;  // empty table and stack
    logic     emit;       // load result registers
    out_src_t src;
    status_t  code;
    logic     alive;
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             rem_zero;
    logic             rem_last;
    logic             can_pop;
    logic             can_append;
    logic             idx_bad;
    logic             ver_match;
    logic             stack_full;
  } sts_t;

  localparam cmd_t CMD_NONE = '{
    load: 1'b0, pop_rd: 1'b0, slot_rd: 1'b0, req_rd: 1'b0, append: 1'b0,
    commit: 1'b0, clear_all: 1'b0, emit: 1'b0, src: SRC_STATUS, code: ST_OK,
    alive: 1'b0
  };

endpackage

>>> design/generational_handle_allocator.sv
// Generational handle allocator top level: ghalloc_ctrl plus ghalloc_dp.
// Accept to strobe: a request is captured and dispatched; status-only results strobe from
// dispatch, appends from S_APPEND, pops and checks after registered memory reads.
// Busy holds until idle; each further pop of a batch repeats the stack and version reads.
// Results go out as one-cycle strobes; the receiver cannot stall them.
// Synchronous reset clears counters, valid and sequencer only; memories have no clearing pass.
module generational_handle_allocator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [ghalloc_pkg::REQ_W-1:0]     req_type,
  input  logic [ghalloc_pkg::COUNT_W-1:0]   count,
  input  logic [ghalloc_pkg::HIDX_W-1:0]    handle_index,
  input  logic [ghalloc_pkg::HVER_W-1:0]    handle_version,
  output logic                              valid,
  output logic [ghalloc_pkg::STATUS_W-1:0]  status,
  output logic [ghalloc_pkg::HIDX_W-1:0]    ent_index,
  output logic [ghalloc_pkg::HVER_W-1:0]    ent_version,
  output logic                              alive,
  output logic                              last
);

  ghalloc_pkg::cmd_t cmd;
  ghalloc_pkg::sts_t sts;

  ghalloc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  ghalloc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .req_type       (req_type),
    .count          (count),
    .handle_index   (handle_index),
    .handle_version (handle_version),
    .cmd            (cmd),
    .sts            (sts),
    .valid          (valid),
    .status         (status),
    .ent_index      (ent_index),
    .ent_version    (ent_version),
    .alive          (alive),
    .last           (last)
  );

`ifndef ASSERT_OFF
  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    valid && !last |-> busy)
    else $error("non-final result while sequencer idle");

  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !valid)
    else $error("result strobe right after accepting a request");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> sts.can_append)
    else $error("append past table capacity");

  a_commit_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> sts.ver_match && !sts.stack_full && !sts.idx_bad)
    else $error("destroy committed without a valid matching handle");
`endif

endmodule

>>> design/ghalloc_dp.sv
// Allocator datapath: version memory, free-slot stack, counters, request
// capture and result registers. Driven by ghalloc_ctrl; uses ghalloc_pkg.
module ghalloc_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [ghalloc_pkg::REQ_W-1:0]     req_type,
  input  logic [ghalloc_pkg::COUNT_W-1:0]   count,
  input  logic [ghalloc_pkg::HIDX_W-1:0]    handle_index,
  input  logic [ghalloc_pkg::HVER_W-1:0]    handle_version,
  input  ghalloc_pkg::cmd_t                 cmd,
  output ghalloc_pkg::sts_t                 sts,
  output logic                              valid,
  output logic [ghalloc_pkg::STATUS_W-1:0]  status,
  output logic [ghalloc_pkg::HIDX_W-1:0]    ent_index,
  output logic [ghalloc_pkg::HVER_W-1:0]    ent_version,
  output logic                              alive,
  output logic                              last
);

  logic [ghalloc_pkg::REQ_W-1:0]  req_q;
  logic [ghalloc_pkg::REM_W-1:0]  rem;
  logic [ghalloc_pkg::REM_W-1:0]  rem_init;
  logic [ghalloc_pkg::HIDX_W-1:0] hidx_q;
  logic [ghalloc_pkg::HVER_W-1:0] hver_q;
  logic [ghalloc_pkg::CNT_W-1:0]  free_count;
  logic [ghalloc_pkg::CNT_W-1:0]  slots_used;
  logic [ghalloc_pkg::IDX_W-1:0]  slot_q;
  logic [ghalloc_pkg::IDX_W-1:0]  hidx_addr;

  logic [ghalloc_pkg::VER_W-1:0]  ver_mem [ghalloc_pkg::MAX_SLOTS];
  logic [ghalloc_pkg::IDX_W-1:0]  stk_mem [ghalloc_pkg::MAX_SLOTS];
  logic [ghalloc_pkg::VER_W-1:0]  ver_rd;
  logic [ghalloc_pkg::IDX_W-1:0]  stk_rd;

  logic                           ver_we;
  logic [ghalloc_pkg::IDX_W-1:0]  ver_wa;
  logic [ghalloc_pkg::VER_W-1:0]  ver_wd;
  logic                           ver_re;
  logic [ghalloc_pkg::IDX_W-1:0]  ver_ra;
  logic [ghalloc_pkg::IDX_W-1:0]  pop_addr;

  assign hidx_addr = ghalloc_pkg::IDX_W'(hidx_q);
  assign pop_addr  = ghalloc_pkg::IDX_W'(free_count - ghalloc_pkg::CNT_W'(1));

  // single create asks for one handle; create-many count is clamped
  always_comb begin
    if (req_type == ghalloc_pkg::REQ_CREATE) begin
      rem_init = ghalloc_pkg::REM_W'(1);
    end else if (32'(count) > 32'(ghalloc_pkg::BATCH_LIM)) begin
      rem_init = ghalloc_pkg::REM_W'(ghalloc_pkg::BATCH_LIM);
    end else begin
      rem_init = ghalloc_pkg::REM_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q  <= req_type;
      hidx_q <= handle_index;
      hver_q <= handle_version;
    end
    if (cmd.slot_rd) begin
      slot_q <= stk_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (cmd.load) begin
      rem <= rem_init;
    end else if (cmd.emit && cmd.src != ghalloc_pkg::SRC_STATUS) begin
      rem <= rem - ghalloc_pkg::REM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      free_count <= '0;
      slots_used <= '0;
    end else begin
      if (cmd.pop_rd) begin
        free_count <= free_count - ghalloc_pkg::CNT_W'(1);
      end else if (cmd.commit) begin
        free_count <= free_count + ghalloc_pkg::CNT_W'(1);
      end
      if (cmd.append) begin
        slots_used <= slots_used + ghalloc_pkg::CNT_W'(1);
      end
    end
  end

  // version memory port control
  always_comb begin
    ver_we = cmd.append || cmd.commit;
    ver_wa = cmd.append ? ghalloc_pkg::IDX_W'(slots_used) : hidx_addr;
    ver_wd = cmd.append ? ghalloc_pkg::VER_W'(1) : ver_rd + ghalloc_pkg::VER_W'(1);
    ver_re = cmd.slot_rd || cmd.req_rd;
    ver_ra = cmd.slot_rd ? stk_rd : hidx_addr;
  end

  always_ff @(posedge clk) begin
    if (ver_we) begin
      ver_mem[ver_wa] <= ver_wd;
    end
    if (ver_re) begin
      ver_rd <= ver_mem[ver_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      stk_mem[ghalloc_pkg::IDX_W'(free_count)] <= hidx_addr;
    end
    if (cmd.pop_rd) begin
      stk_rd <= stk_mem[pop_addr];
    end
  end

  always_comb begin
    sts.req        = req_q;
    sts.rem_zero   = (rem == '0);
    sts.rem_last   = (rem == ghalloc_pkg::REM_W'(1));
    sts.can_pop    = (32'(free_count) >= 32'(rem));
    sts.can_append = ((32'(ghalloc_pkg::MAX_SLOTS) - 32'(slots_used)) >= 32'(rem));
    sts.idx_bad    = (32'(hidx_q) >= 32'(slots_used)) ||
                     (32'(hidx_q) >= 32'(ghalloc_pkg::MAX_SLOTS));
    sts.ver_match  = (32'(ver_rd) == 32'(hver_q));
    sts.stack_full = (32'(free_count) >= 32'(ghalloc_pkg::MAX_SLOTS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      unique case (cmd.src)
        ghalloc_pkg::SRC_POP: begin
          status      <= ghalloc_pkg::ST_OK;
          ent_index   <= ghalloc_pkg::HIDX_W'(slot_q);
          ent_version <= ghalloc_pkg::HVER_W'(ver_rd);
          alive       <= 1'b0;
          last        <= sts.rem_last;
        end
        ghalloc_pkg::SRC_APPEND: begin
          status      <= ghalloc_pkg::ST_OK;
          ent_index   <= ghalloc_pkg::HIDX_W'(slots_used);
          ent_version <= ghalloc_pkg::HVER_W'(ghalloc_pkg::VER_W'(1));
          alive       <= 1'b0;
          last        <= sts.rem_last;
        end
        default: begin
          status      <= cmd.code;
          ent_index   <= '0;
          ent_version <= '0;
          alive       <= cmd.alive;
          last        <= 1'b1;
        end
      endcase
    end
  end

endmodule

>>> design/ghalloc_ctrl.sv
// Allocator controller: one-hot sequencer that steps each request through
// the datapath. Uses ghalloc_pkg command and status structs.
module ghalloc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ghalloc_pkg::sts_t sts,
  output ghalloc_pkg::cmd_t cmd,
  output logic              busy
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DISPATCH = 6'b000010,
    S_POP_VER  = 6'b000100,
    S_POP_EMIT = 6'b001000,
    S_APPEND   = 6'b010000,
    S_CHECK    = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = ghalloc_pkg::CMD_NONE;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (sts.req == ghalloc_pkg::REQ_CREATE ||
                     sts.req == ghalloc_pkg::REQ_CREATE_MANY) begin
          priority if (sts.rem_zero) begin
            state_next = S_IDLE;
          end else if (sts.can_pop) begin
            cmd.pop_rd = 1'b1;
            state_next = S_POP_VER;
          end else if (sts.can_append) begin
            state_next = S_APPEND;
          end else begin
            cmd.emit   = 1'b1;
            cmd.code   = ghalloc_pkg::ST_FULL;
            state_next = S_IDLE;
          end
        end else if (sts.req == ghalloc_pkg::REQ_DESTROY ||
                     sts.req == ghalloc_pkg::REQ_IS_ALIVE) begin
          if (sts.idx_bad) begin
            cmd.emit   = 1'b1;
            cmd.code   = ghalloc_pkg::ST_BAD_INDEX;
            state_next = S_IDLE;
          end else begin
            cmd.req_rd = 1'b1;
            state_next = S_CHECK;
          end
        end else if (sts.req == ghalloc_pkg::REQ_CLEAR) begin
          cmd.clear_all = 1'b1;
          cmd.emit      = 1'b1;
          state_next    = S_IDLE;
        end else begin
          // drop unknown request types
          state_next = S_IDLE;
        end
      end
      S_POP_VER: begin
        cmd.slot_rd = 1'b1;
        state_next  = S_POP_EMIT;
      end
      S_POP_EMIT: begin
        cmd.emit = 1'b1;
        cmd.src  = ghalloc_pkg::SRC_POP;
        if (sts.rem_last) begin
          state_next = S_IDLE;
        end else begin
          cmd.pop_rd = 1'b1;
          state_next = S_POP_VER;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        cmd.emit   = 1'b1;
        cmd.src    = ghalloc_pkg::SRC_APPEND;
        if (sts.rem_last) begin
          state_next = S_IDLE;
        end
      end
      S_CHECK: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
        priority if (sts.req == ghalloc_pkg::REQ_IS_ALIVE) begin
          cmd.alive = sts.ver_match;
        end else if (!sts.ver_match) begin
          cmd.code = ghalloc_pkg::ST_OK;
        end else if (sts.stack_full) begin
          cmd.code = ghalloc_pkg::ST_FULL;
        end else begin
          cmd.commit = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
